// File: rtl/ansi_escape_stripper_defines.svh
// ---------------------------------------------------------------------------
// assertion macros for the escape stripper checker
// ---------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_STRIPPER_DEFINES_SVH
`define ANSI_ESCAPE_STRIPPER_DEFINES_SVH

// clocked check, switched off while reset is high
`define AES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define AES_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/aes_pkg.sv
// ---------------------------------------------------------------------------
// aes_pkg
// shared byte codes, csi final byte decode and result types
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aes_pkg;

  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_BEL      = 8'h07;
  localparam logic [7:0] BYTE_OSC_OPEN = 8'h5D; // ']'
  localparam logic [7:0] BYTE_CSI_OPEN = 8'h5B; // '['

  // number of result slots in the output queue
  localparam int unsigned QUEUE_SLOTS = 2;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_terminator;
  } aes_res_t;

  // results handed from the parser to the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    aes_res_t   first;
    aes_res_t   second;
  } aes_push_t;

  // final bytes that close a csi sequence
  function automatic logic csi_final(input logic [7:0] b);
    logic hit;
    case (b)
      "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "S", "T",
      "f", "m", "n", "s", "u": hit = 1'b1;
      default:                 hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: rtl/aes_if.sv
// ---------------------------------------------------------------------------
// aes stream interfaces
// valid/ready channels for input bytes and result items
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface aes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;

  modport source (output valid, output out_byte, output is_terminator, input ready);
  modport sink   (input valid, input out_byte, input is_terminator, output ready);
endinterface

// File: rtl/aes_outq.sv
// ---------------------------------------------------------------------------
// aes_outq
// two-slot result queue, up to two results in per cycle, one out when ready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_outq (
  input  logic              clk,
  input  logic              rst,
  input  aes_pkg::aes_push_t push,
  output logic [1:0]        free_slots,
  aes_out_if.source         out_ch
);
  import aes_pkg::*;

  aes_res_t   slots [QUEUE_SLOTS];
  aes_res_t   slots_next [QUEUE_SLOTS];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] base;
  logic       pop;

  // front slot drives the channel
  assign out_ch.valid         = (cnt != 2'd0);
  assign out_ch.out_byte      = slots[0].out_byte;
  assign out_ch.is_terminator = slots[0].is_terminator;
  assign pop                  = out_ch.valid && out_ch.ready;

  // room left once this cycle's transfer has gone
  assign free_slots = 2'd2 - cnt + {1'b0, pop};

  // shift on transfer, then append new results behind what remains
  always_comb begin
    base       = cnt - {1'b0, pop};
    slots_next = slots;
    if (pop) begin
      slots_next[0] = slots[1];
    end
    case (push.count)
      2'd1: begin
        slots_next[base[0]] = push.first;
      end
      2'd2: begin
        slots_next[0] = push.first;
        slots_next[1] = push.second;
      end
      default: begin
      end
    endcase
    cnt_next = base + push.count;
  end

  // payload slots need no reset
  always_ff @(posedge clk) begin
    slots <= slots_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule

// File: rtl/ansi_escape_stripper.sv
// path: a kept byte or terminator goes through the byte register, then a result queue slot
// throughput: one byte per cycle while the queue has room; a kept byte with end_of_buffer
//   gives two results, and the output side, one result per cycle if ready, sets the pace
// the byte register and the two-slot result queue decouple the two sides
// reset: synchronous, clears the parse mode to normal and empties both stages
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// ansi_escape_stripper
// drops osc and csi escape sequences from a terminal byte stream
// ---------------------------------------------------------------------------
module ansi_escape_stripper (
  input  logic      clk,
  input  logic      rst,
  aes_in_if.sink    in_ch,
  aes_out_if.source out_ch
);
  import aes_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_OSC,
    MODE_CSI
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eob;
  logic       keep;
  logic [1:0] n_res;
  logic [1:0] free_slots;
  logic       advance;
  aes_push_t  push;

  // parse of the registered byte
  always_comb begin
    keep      = 1'b0;
    mode_next = mode;
    case (mode)
      MODE_NORMAL: begin
        if (s1_byte == BYTE_ESC) begin
          mode_next = MODE_ESC;
        end else begin
          keep = 1'b1;
        end
      end
      MODE_ESC: begin
        if (s1_byte == BYTE_OSC_OPEN) begin
          mode_next = MODE_OSC;
        end else if (s1_byte == BYTE_CSI_OPEN) begin
          mode_next = MODE_CSI;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_OSC: begin
        if (s1_byte == BYTE_BEL) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (csi_final(s1_byte)) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase
    // buffer end abandons any open sequence
    if (s1_eob) begin
      mode_next = MODE_NORMAL;
    end
  end

  // results of this byte and whether the queue can take them
  assign n_res   = {1'b0, keep} + {1'b0, s1_eob};
  assign advance = s1_valid && (n_res <= free_slots);
  assign in_ch.ready = !s1_valid || advance;

  // kept byte first, terminator last
  always_comb begin
    push.count                = advance ? n_res : 2'd0;
    push.first.out_byte       = keep ? s1_byte : 8'h00;
    push.first.is_terminator  = !keep;
    push.second.out_byte      = 8'h00;
    push.second.is_terminator = 1'b1;
  end

  // byte register and parse mode
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      mode     <= MODE_NORMAL;
    end else begin
      if (advance) begin
        mode <= mode_next;
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_valid <= 1'b1;
        s1_byte  <= in_ch.data_byte;
        s1_eob   <= in_ch.end_of_buffer;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  aes_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .free_slots (free_slots),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/aes_checker.sv
// ---------------------------------------------------------------------------
// aes_checker
// port-level checks on the escape stripper, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ansi_escape_stripper_defines.svh"

module aes_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_terminator
);
  import aes_pkg::*;

  // a result held back by the sink stays put with the same payload
  property p_out_hold;
    out_valid && !out_ready |=>
      out_valid && $stable(out_byte) && $stable(is_terminator);
  endproperty

  // stalled result keeps its payload
  `AES_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

  // input only stalls while a result is pending on the output side
  `AES_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled with no result pending")

  // an escape byte is never passed on
  `AES_ASSERT(a_no_esc, out_valid && !is_terminator |-> out_byte != BYTE_ESC, "escape byte passed on")

  // nothing pending right after reset
  `AES_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result pending after reset")

endmodule

bind ansi_escape_stripper aes_checker u_aes_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .is_terminator (out_ch.is_terminator)
);
